// ===== rtl/core/xxh_pkg.sv =====
`default_nettype none
package xxh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIPE,
    ST_CONV,
    ST_MERGE,
    ST_TAILW,
    ST_TAIL4,
    ST_TAILB,
    ST_AVAL,
    ST_OUT
  } state_t;

  // One datapath operation per step; multi-step ops iterate via phase.
  // Each multiply step runs through sub 0..2; registers update on sub 2.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STRIPE,
    OP_CONV,
    OP_MERGE,
    OP_TAILW,
    OP_TAIL4,
    OP_TAILB,
    OP_AVAL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] phase;
    logic [1:0] idx;
    logic [1:0] sub;
  } cmd_t;

  typedef struct packed {
    logic       last;
    logic       full_last;
    logic       do_stripe;
    logic       striped;
    logic [1:0] nbuf;
    logic [3:0] rem;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/xxh_stream_if.sv =====
`default_nettype none
interface xxh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface xxh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash;
  modport source (output valid, hash, input ready);
  modport sink (input valid, hash, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/xxh_datapath.sv =====
`default_nettype none
module xxh_datapath (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [63:0]  seed,
  input  wire logic [63:0]  data_word,
  input  wire logic [3:0]   byte_count,
  input  wire logic         last,
  input  wire xxh_pkg::cmd_t cmd,
  output xxh_pkg::stat_t    stat,
  output logic [63:0]       hash
);

  logic [63:0] lane [4];
  logic [63:0] sbuf [3];
  logic [1:0]  nbuf;
  logic [63:0] total;
  logic        striped;
  logic        opened;
  logic [63:0] word;
  logic [3:0]  rem;
  logic        wlast;
  logic [63:0] h;
  logic [63:0] t;      // product / scratch register between multiplies
  logic [3:0]  cnt_sat;
  logic        full;
  logic [63:0] mul_a, mul_b, prod;
  logic [63:0] lane_sel, buf_sel;
  logic [31:0] m_x, m_y;
  logic [63:0] mul32;
  logic [63:0] acc;    // partial product across the multiply sub-steps (sub 0..2)
  logic        step_end;

  assign cnt_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;
  assign full    = !wlast || (rem == 4'd8);
  assign lane_sel = lane[cmd.idx];
  assign buf_sel  = (cmd.idx == 2'd0) ? sbuf[0] : (cmd.idx == 2'd1) ? sbuf[1] : sbuf[2];
  assign step_end = (cmd.sub == 2'd2);

  function automatic logic [63:0] rotl(input logic [63:0] v, input int s);
    rotl = (v << s) | (v >> (64 - s));
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    mul_a = t;
    mul_b = xxh_pkg::P1;
    case (cmd.op)
      xxh_pkg::OP_STRIPE, xxh_pkg::OP_MERGE, xxh_pkg::OP_TAILW: begin
        case (cmd.phase)
          3'd0: begin
            mul_a = (cmd.op == xxh_pkg::OP_STRIPE)
                    ? ((cmd.idx == 2'd3) ? word : buf_sel)
                    : (cmd.op == xxh_pkg::OP_MERGE) ? lane_sel : buf_sel;
            mul_b = xxh_pkg::P2;
          end
          3'd1: begin
            mul_a = (cmd.op == xxh_pkg::OP_STRIPE) ? rotl(lane_sel + t, 31) : rotl(t, 31);
            mul_b = xxh_pkg::P1;
          end
          default: begin
            mul_a = (cmd.op == xxh_pkg::OP_MERGE) ? (h ^ t) : rotl(h ^ t, 27);
            mul_b = xxh_pkg::P1;
          end
        endcase
      end
      xxh_pkg::OP_TAIL4: begin
        mul_a = (cmd.phase == 3'd0) ? {32'd0, word[31:0]} : rotl(h ^ t, 23);
        mul_b = (cmd.phase == 3'd0) ? xxh_pkg::P1 : xxh_pkg::P2;
      end
      xxh_pkg::OP_TAILB: begin
        mul_a = (cmd.phase == 3'd0) ? {56'd0, word[7:0]} : rotl(h ^ t, 11);
        mul_b = (cmd.phase == 3'd0) ? xxh_pkg::P5 : xxh_pkg::P1;
      end
      xxh_pkg::OP_AVAL: begin
        mul_a = (cmd.phase == 3'd0) ? (h ^ (h >> 33)) : (h ^ (h >> 29));
        mul_b = (cmd.phase == 3'd0) ? xxh_pkg::P2 : xxh_pkg::P3;
      end
      default: begin
        mul_a = t;
        mul_b = xxh_pkg::P1;
      end
    endcase
  end

  // low 64 bits of mul_a * mul_b on one 32x32 multiplier:
  // sub 0 lo*lo, sub 1 adds lo*hi << 32, sub 2 adds hi*lo << 32
  always_comb begin
    case (cmd.sub)
      2'd0: begin
        m_x = mul_a[31:0];
        m_y = mul_b[31:0];
      end
      2'd1: begin
        m_x = mul_a[31:0];
        m_y = mul_b[63:32];
      end
      default: begin
        m_x = mul_a[63:32];
        m_y = mul_b[31:0];
      end
    endcase
  end
  assign mul32 = 64'(m_x) * 64'(m_y);
  assign prod  = acc + {mul32[31:0], 32'd0};

  always_ff @(posedge clk) begin
    acc <= (cmd.sub == 2'd0) ? mul32 : prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opened  <= 1'b0;
      nbuf    <= 2'd0;
      striped <= 1'b0;
      total   <= 64'd0;
    end else begin
      case (cmd.op)
        xxh_pkg::OP_LOAD: begin
          word  <= data_word;
          wlast <= last;
          rem   <= last ? cnt_sat : 4'd8;
          if (!opened) begin
            lane[0] <= seed + xxh_pkg::P1 + xxh_pkg::P2;
            lane[1] <= seed + xxh_pkg::P2;
            lane[2] <= seed;
            lane[3] <= seed - xxh_pkg::P1;
            nbuf    <= 2'd0;
            striped <= 1'b0;
            total   <= {60'd0, last ? cnt_sat : 4'd8};
            opened  <= 1'b1;
          end else begin
            total <= total + {60'd0, last ? cnt_sat : 4'd8};
          end
        end
        xxh_pkg::OP_STRIPE: begin
          if (step_end) begin
            if (cmd.phase == 3'd0) t <= prod;
            else begin
              lane[cmd.idx] <= prod;
              if (cmd.idx == 2'd3) begin
                nbuf    <= 2'd0;
                striped <= 1'b1;
                if (wlast) rem <= 4'd0;
              end
            end
          end
        end
        xxh_pkg::OP_CONV: begin
          if (!stat.do_stripe && full) begin
            sbuf[nbuf] <= word;
            nbuf       <= nbuf + 2'd1;
            if (wlast) rem <= 4'd0;
          end
          // without a stripe the length goes in here, else after the merge
          if (wlast) begin
            h <= striped || stat.do_stripe ? (rotl(lane[0], 1) + rotl(lane[1], 7) +
                 rotl(lane[2], 12) + rotl(lane[3], 18)) : lane[2] + xxh_pkg::P5 + total;
          end
        end
        xxh_pkg::OP_MERGE: begin
          if (step_end) begin
            if (cmd.phase == 3'd2) begin
              h <= (cmd.idx == 2'd3) ? prod + xxh_pkg::P4 + total : prod + xxh_pkg::P4;
            end else t <= prod;
          end
        end
        xxh_pkg::OP_TAILW: begin
          if (step_end) begin
            if (cmd.phase == 3'd2) h <= prod + xxh_pkg::P4;
            else t <= prod;
          end
        end
        xxh_pkg::OP_TAIL4: begin
          if (step_end) begin
            if (cmd.phase == 3'd0) t <= prod;
            else begin
              h    <= prod + xxh_pkg::P3;
              word <= word >> 32;
              rem  <= rem - 4'd4;
            end
          end
        end
        xxh_pkg::OP_TAILB: begin
          if (step_end) begin
            if (cmd.phase == 3'd0) t <= prod;
            else begin
              h    <= prod;
              word <= word >> 8;
              rem  <= rem - 4'd1;
            end
          end
        end
        xxh_pkg::OP_AVAL: begin
          if (step_end) begin
            if (cmd.phase == 3'd0) h <= prod;
            else if (cmd.phase == 3'd1) h <= prod;
            else begin
              h       <= h ^ (h >> 32);
              opened  <= 1'b0;
              nbuf    <= 2'd0;
              striped <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.last      = wlast;
  assign stat.full_last = full;
  assign stat.do_stripe = full && (nbuf == 2'd3);
  assign stat.striped   = striped;
  assign stat.nbuf      = nbuf;
  assign stat.rem       = rem;
  assign hash           = h;

endmodule
`default_nettype wire

// ===== rtl/core/xxh_ctrl.sv =====
`default_nettype none
module xxh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire xxh_pkg::stat_t stat,
  output xxh_pkg::cmd_t      cmd
);

  xxh_pkg::state_t state, state_next;
  logic [2:0] phase, phase_next;
  logic [1:0] idx, idx_next;
  logic [1:0] sub, sub_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xxh_pkg::ST_IDLE;
      phase <= 3'd0;
      idx   <= 2'd0;
      sub   <= 2'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      idx   <= idx_next;
      sub   <= sub_next;
    end
  end

  // a multiply step holds phase/idx while sub runs 0..2
  always_comb begin
    state_next = state;
    phase_next = phase;
    idx_next   = idx;
    sub_next   = 2'd0;
    case (state)
      xxh_pkg::ST_IDLE: if (in_valid) begin
        state_next = xxh_pkg::ST_CONV;
        phase_next = 3'd0;
      end
      xxh_pkg::ST_CONV: begin
        phase_next = 3'd0;
        idx_next   = 2'd0;
        if (stat.do_stripe) state_next = xxh_pkg::ST_STRIPE;
        else if (!stat.last) state_next = xxh_pkg::ST_IDLE;
        else if (stat.striped) state_next = xxh_pkg::ST_MERGE;
        else state_next = xxh_pkg::ST_TAILW;
      end
      xxh_pkg::ST_STRIPE: begin
        if (sub != 2'd2) sub_next = sub + 2'd1;
        else if (phase == 3'd1) begin
          phase_next = 3'd0;
          idx_next   = idx + 2'd1;
          if (idx == 2'd3) state_next = stat.last ? xxh_pkg::ST_CONV : xxh_pkg::ST_IDLE;
        end else phase_next = 3'd1;
      end
      xxh_pkg::ST_MERGE: begin
        if (sub != 2'd2) sub_next = sub + 2'd1;
        else if (phase == 3'd2) begin
          phase_next = 3'd0;
          idx_next   = idx + 2'd1;
          if (idx == 2'd3) state_next = xxh_pkg::ST_TAILW;
        end else phase_next = phase + 3'd1;
      end
      xxh_pkg::ST_TAILW: begin
        if (idx >= stat.nbuf) begin
          state_next = xxh_pkg::ST_TAIL4;
          phase_next = 3'd0;
          idx_next   = 2'd0;
        end else if (sub != 2'd2) sub_next = sub + 2'd1;
        else if (phase == 3'd2) begin
          phase_next = 3'd0;
          idx_next   = idx + 2'd1;
        end else phase_next = phase + 3'd1;
      end
      xxh_pkg::ST_TAIL4: begin
        if (stat.rem < 4'd4) state_next = xxh_pkg::ST_TAILB;
        else if (sub != 2'd2) sub_next = sub + 2'd1;
        else if (phase == 3'd1) begin
          phase_next = 3'd0;
          state_next = xxh_pkg::ST_TAILB;
        end else phase_next = 3'd1;
      end
      xxh_pkg::ST_TAILB: begin
        if (stat.rem == 4'd0) begin
          state_next = xxh_pkg::ST_AVAL;
          phase_next = 3'd0;
        end else if (sub != 2'd2) sub_next = sub + 2'd1;
        else phase_next = (phase == 3'd1) ? 3'd0 : 3'd1;
      end
      xxh_pkg::ST_AVAL: begin
        if (sub != 2'd2) sub_next = sub + 2'd1;
        else if (phase == 3'd2) state_next = xxh_pkg::ST_OUT;
        else phase_next = phase + 3'd1;
      end
      xxh_pkg::ST_OUT: if (out_ready) state_next = xxh_pkg::ST_IDLE;
      default: state_next = xxh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == xxh_pkg::ST_IDLE);
    out_valid = (state == xxh_pkg::ST_OUT);
    cmd.phase = phase;
    cmd.idx   = idx;
    cmd.sub   = sub;
    case (state)
      xxh_pkg::ST_IDLE:   cmd.op = in_valid ? xxh_pkg::OP_LOAD : xxh_pkg::OP_NONE;
      xxh_pkg::ST_CONV:   cmd.op = xxh_pkg::OP_CONV;
      xxh_pkg::ST_STRIPE: cmd.op = xxh_pkg::OP_STRIPE;
      xxh_pkg::ST_MERGE:  cmd.op = xxh_pkg::OP_MERGE;
      xxh_pkg::ST_TAILW:  cmd.op = (idx >= stat.nbuf) ? xxh_pkg::OP_NONE : xxh_pkg::OP_TAILW;
      xxh_pkg::ST_TAIL4:  cmd.op = (stat.rem < 4'd4) ? xxh_pkg::OP_NONE : xxh_pkg::OP_TAIL4;
      xxh_pkg::ST_TAILB:  cmd.op = (stat.rem == 4'd0) ? xxh_pkg::OP_NONE : xxh_pkg::OP_TAILB;
      xxh_pkg::ST_AVAL:   cmd.op = xxh_pkg::OP_AVAL;
      default:            cmd.op = xxh_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/xxh64_stream_hasher_core.sv =====
`default_nettype none
// XXH64 stream hasher.
// Input channel (in): one request per 64-bit little-endian message word with
// byte_count and last. Output channel (out): one hash per message, issued after
// the word marked last. cfg_we/cfg_wdata write the seed; the seed is sampled
// when the first word of a message is taken.
// Processing: a plain word is accepted, then buffered; no new word is taken
// until the previous one is through. Every 64-bit multiply runs on one shared
// 32x32 multiplier. A word that completes a stripe adds four lane rounds, two
// dependent multiplies each. The last word adds: the merge if a stripe was
// taken (plus another conversion step if that word closed the stripe), three
// multiplies per buffered tail word, two for the 4-byte piece, two per trailing
// byte, the state checks, the avalanche and the out state.
// The hash is held on out until taken.
// Reset (rst, synchronous) clears the controller and closes any open message;
// the seed returns to zero. While out is stalled no new word is accepted.
module xxh64_stream_hasher_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [63:0] cfg_wdata,
  xxh_in_if.sink          in,
  xxh_out_if.source       out
);

  logic [63:0]     seed;
  xxh_pkg::cmd_t   cmd;
  xxh_pkg::stat_t  stat;

  always_ff @(posedge clk) begin
    if (rst) seed <= 64'd0;
    else if (cfg_we) seed <= cfg_wdata;
  end

  xxh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .stat(stat), .cmd(cmd)
  );

  xxh_datapath u_dp (
    .clk(clk), .rst(rst), .seed(seed),
    .data_word(in.data_word), .byte_count(in.byte_count), .last(in.last),
    .cmd(cmd), .stat(stat), .hash(out.hash)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in.ready && out.valid)) else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.hash))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
